@@ sv/stl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the script token lexer.
// No dependencies; every other file imports this package.
package stl_pkg;

  // Sizing
  localparam int MAX_LEXEME  = 63;
  localparam int TOKEN_LIMIT = 4096;
  localparam int OFFSET_BITS = 16;
  localparam int MAX_RES     = 3;
  localparam int LEN_W       = 6;
  localparam int LINE_W      = 16;
  localparam int IDX_W       = 12;
  localparam int OFF_W       = OFFSET_BITS;
  localparam int CNT_W       = 2;

  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_LEXEME);
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);
  localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(TOKEN_LIMIT - 1);

  // Bundle queue between the scanner and the token serializer
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  // Token kinds
  typedef enum logic [3:0] {
    TK_LST    = 4'd0,
    TK_WHN    = 4'd1,
    TK_TRN    = 4'd2,
    TK_SUM    = 4'd3,
    TK_EMT    = 4'd4,
    TK_IDENT  = 4'd5,
    TK_NUMBER = 4'd6,
    TK_PIPE   = 4'd7,
    TK_ARROW  = 4'd8,
    TK_LBRACK = 4'd9,
    TK_RBRACK = 4'd10,
    TK_ASSIGN = 4'd11,
    TK_OP     = 4'd12,
    TK_ERROR  = 4'd13,
    TK_EOF    = 4'd14
  } tok_kind_t;

  // Operator codes; non-operator tokens carry OP_NONE
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_GT    = 4'd4;
  localparam logic [3:0] OP_LT    = 4'd5;
  localparam logic [3:0] OP_NOT   = 4'd6;
  localparam logic [3:0] OP_XOR   = 4'd7;
  localparam logic [3:0] OP_COMMA = 4'd8;
  localparam logic [3:0] OP_GE    = 4'd9;
  localparam logic [3:0] OP_LE    = 4'd10;
  localparam logic [3:0] OP_NE    = 4'd11;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  // Keywords, first character in the top byte
  localparam logic [23:0] KW_LST = "lst";
  localparam logic [23:0] KW_WHN = "whn";
  localparam logic [23:0] KW_TRN = "trn";
  localparam logic [23:0] KW_SUM = "sum";
  localparam logic [23:0] KW_EMT = "emt";

  typedef struct packed {
    tok_kind_t         kind;
    logic [3:0]        op;
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic [IDX_W-1:0]  index;
  } tok_t;

  // All tokens caused by one source byte
  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    tok_t [MAX_RES-1:0]       toks;
  } bundle_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Three-letter keywords, everything else is an identifier
  function automatic tok_kind_t ident_kind(logic [23:0] prefix, logic [LEN_W-1:0] len);
    tok_kind_t k;
    k = TK_IDENT;
    if (len == LEN_W'(3)) begin
      unique case (prefix)
        KW_LST:  k = TK_LST;
        KW_WHN:  k = TK_WHN;
        KW_TRN:  k = TK_TRN;
        KW_SUM:  k = TK_SUM;
        KW_EMT:  k = TK_EMT;
        default: k = TK_IDENT;
      endcase
    end
    return k;
  endfunction

  // Comparison operator from the held first character
  function automatic logic [3:0] cmp_op(logic [7:0] c, logic with_eq);
    logic [3:0] op;
    if (c == CH_GT)      op = with_eq ? OP_GE : OP_GT;
    else if (c == CH_LT) op = with_eq ? OP_LE : OP_LT;
    else                 op = with_eq ? OP_NE : OP_NOT;
    return op;
  endfunction

  function automatic tok_t make_tok(tok_kind_t kind, logic [3:0] op, logic [OFF_W-1:0] start,
                                    logic [LEN_W-1:0] len, logic [LINE_W-1:0] line);
    tok_t t;
    t.kind  = kind;
    t.op    = op;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.index = '0;
    return t;
  endfunction

endpackage

@@ sv/stl_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for source beats and token beats.
// Depends on stl_pkg for field widths.
interface stl_in_if import stl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_of_source;

  modport source (output valid, output src_byte, output end_of_source, input ready);
  modport sink   (input valid, input src_byte, input end_of_source, output ready);
endinterface

interface stl_out_if import stl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [3:0]        token_kind;
  logic [3:0]        op_code;
  logic [15:0]       start_offset;
  logic [LEN_W-1:0]  lexeme_length;
  logic [LINE_W-1:0] line_number;
  logic [IDX_W-1:0]  token_index;
  logic              last_of_run;

  modport source (output valid, output token_kind, output op_code, output start_offset,
                  output lexeme_length, output line_number, output token_index,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input op_code, input start_offset,
                  input lexeme_length, input line_number, input token_index,
                  input last_of_run, output ready);
endinterface

@@ sv/stl_front.sv @@
`timescale 1ns / 1ps
// Scanner front end: classifies one source byte per beat and builds the bundle
// of up to three tokens it causes. Depends on stl_pkg and stl_in_if.
module stl_front import stl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  stl_in_if.sink  in_ch,
  output logic    push_valid,
  output bundle_t push_data,
  input  logic    push_ready
);

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_COMMENT = 9'b000000010,
    M_IDENT   = 9'b000000100,
    M_INT     = 9'b000001000,
    M_DOT     = 9'b000010000,
    M_FRAC    = 9'b000100000,
    M_MINUS   = 9'b001000000,
    M_CMP     = 9'b010000000,
    M_HALT    = 9'b100000000
  } lex_mode_t;

  lex_mode_t         mode_r, mode_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic [OFF_W-1:0]  tstart_r, tstart_nxt;
  logic [LEN_W-1:0]  lcnt_r, lcnt_nxt;
  logic [OFF_W-1:0]  bpos_r, bpos_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [23:0]       kwp_r, kwp_nxt;
  logic [IDX_W-1:0]  temit_r, temit_nxt;

  tok_t              tk_nxt [MAX_RES];
  logic [CNT_W-1:0]  n_nxt;
  logic              in_acc;

  assign in_ch.ready = push_ready;
  assign in_acc      = in_ch.valid & push_ready;

  // Next state and emitted tokens for the byte on the input
  always_comb begin
    logic [7:0]       c;
    logic [OFF_W-1:0] pos;
    logic             last;
    logic             run_idle;

    c         = in_ch.src_byte;
    pos       = bpos_r;
    last      = in_ch.end_of_source | (c == CH_NUL);
    run_idle  = 1'b0;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    tstart_nxt = tstart_r;
    lcnt_nxt  = lcnt_r;
    bpos_nxt  = bpos_r;
    line_nxt  = line_r;
    kwp_nxt   = kwp_r;
    temit_nxt = temit_r;
    n_nxt     = '0;
    for (int i = 0; i < MAX_RES; i++) tk_nxt[i] = '0;

    if (c != CH_NUL) begin
      // Continue or close the lexeme in progress
      unique case (mode_nxt)
        M_HALT: begin
        end
        M_COMMENT: begin
          if (c == CH_LF) run_idle = 1'b1;
        end
        M_IDENT: begin
          if (is_letter(c) && lcnt_nxt < LEN_MAX) begin
            if (lcnt_nxt == LEN_W'(1))      kwp_nxt[15:8] = c;
            else if (lcnt_nxt == LEN_W'(2)) kwp_nxt[7:0]  = c;
            lcnt_nxt = lcnt_nxt + LEN_W'(1);
          end else begin
            tk_nxt[n_nxt] = make_tok(ident_kind(kwp_nxt, lcnt_nxt), OP_NONE, tstart_nxt,
                                     lcnt_nxt, line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c) && lcnt_nxt < LEN_MAX) begin
            lcnt_nxt = lcnt_nxt + LEN_W'(1);
          end else if (c == CH_DOT && lcnt_nxt < LEN_MAX) begin
            mode_nxt = M_DOT;
          end else begin
            tk_nxt[n_nxt] = make_tok(TK_NUMBER, OP_NONE, tstart_nxt, lcnt_nxt, line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            lcnt_nxt = lcnt_nxt + LEN_W'(1);
            if (lcnt_nxt < LEN_MAX) begin
              lcnt_nxt = lcnt_nxt + LEN_W'(1);
              mode_nxt = M_FRAC;
            end else begin
              // dot reached the limit: the digit opens a new number
              tk_nxt[n_nxt] = make_tok(TK_NUMBER, OP_NONE, tstart_nxt, lcnt_nxt, line_nxt);
              n_nxt = n_nxt + CNT_W'(1);
              run_idle = 1'b1;
            end
          end else begin
            // lone dot: close the number, then flag the dot itself
            tk_nxt[n_nxt] = make_tok(TK_NUMBER, OP_NONE, tstart_nxt, lcnt_nxt, line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            tk_nxt[n_nxt] = make_tok(TK_ERROR, OP_NONE, tstart_nxt + OFF_W'(lcnt_nxt),
                                     '0, line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            mode_nxt = M_HALT;
          end
        end
        M_FRAC: begin
          if (is_digit(c) && lcnt_nxt < LEN_MAX) begin
            lcnt_nxt = lcnt_nxt + LEN_W'(1);
          end else begin
            tk_nxt[n_nxt] = make_tok(TK_NUMBER, OP_NONE, tstart_nxt, lcnt_nxt, line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_MINUS: begin
          if (is_digit(c)) begin
            mode_nxt = M_INT;
            lcnt_nxt = LEN_W'(2);
          end else if (c == CH_GT) begin
            tk_nxt[n_nxt] = make_tok(TK_ARROW, OP_NONE, tstart_nxt, LEN_W'(2), line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            mode_nxt = M_IDLE;
          end else begin
            tk_nxt[n_nxt] = make_tok(TK_OP, OP_SUB, tstart_nxt, LEN_W'(1), line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_CMP: begin
          if (c == CH_EQ) begin
            tk_nxt[n_nxt] = make_tok(TK_OP, cmp_op(pend_nxt, 1'b1), tstart_nxt, LEN_W'(2),
                                     line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            mode_nxt = M_IDLE;
          end else begin
            tk_nxt[n_nxt] = make_tok(TK_OP, cmp_op(pend_nxt, 1'b0), tstart_nxt, LEN_W'(1),
                                     line_nxt);
            n_nxt = n_nxt + CNT_W'(1);
            run_idle = 1'b1;
          end
        end
        M_IDLE: begin
          run_idle = 1'b1;
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      // Classify the byte as the start of something new
      if (run_idle) begin
        mode_nxt = M_IDLE;
        priority if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
        end else if (c == CH_LF) begin
          if (line_nxt != LINE_MAX) line_nxt = line_nxt + LINE_W'(1);
        end else if (c == CH_HASH) begin
          mode_nxt = M_COMMENT;
        end else if (is_letter(c)) begin
          mode_nxt   = M_IDENT;
          tstart_nxt = pos;
          lcnt_nxt   = LEN_W'(1);
          kwp_nxt    = {c, 16'h0000};
        end else if (is_digit(c)) begin
          mode_nxt   = M_INT;
          tstart_nxt = pos;
          lcnt_nxt   = LEN_W'(1);
        end else if (c == CH_MINUS) begin
          mode_nxt   = M_MINUS;
          tstart_nxt = pos;
        end else if (c == CH_GT || c == CH_LT || c == CH_BANG) begin
          mode_nxt   = M_CMP;
          tstart_nxt = pos;
          pend_nxt   = c;
        end else begin
          unique case (c)
            CH_PIPE:   tk_nxt[n_nxt] = make_tok(TK_PIPE, OP_NONE, pos, LEN_W'(1), line_nxt);
            CH_LBRACK: tk_nxt[n_nxt] = make_tok(TK_LBRACK, OP_NONE, pos, LEN_W'(1), line_nxt);
            CH_RBRACK: tk_nxt[n_nxt] = make_tok(TK_RBRACK, OP_NONE, pos, LEN_W'(1), line_nxt);
            CH_EQ:     tk_nxt[n_nxt] = make_tok(TK_ASSIGN, OP_NONE, pos, LEN_W'(1), line_nxt);
            CH_COMMA:  tk_nxt[n_nxt] = make_tok(TK_OP, OP_COMMA, pos, LEN_W'(1), line_nxt);
            CH_PLUS:   tk_nxt[n_nxt] = make_tok(TK_OP, OP_ADD, pos, LEN_W'(1), line_nxt);
            CH_STAR:   tk_nxt[n_nxt] = make_tok(TK_OP, OP_MUL, pos, LEN_W'(1), line_nxt);
            CH_SLASH:  tk_nxt[n_nxt] = make_tok(TK_OP, OP_DIV, pos, LEN_W'(1), line_nxt);
            CH_CARET:  tk_nxt[n_nxt] = make_tok(TK_OP, OP_XOR, pos, LEN_W'(1), line_nxt);
            default: begin
              tk_nxt[n_nxt] = make_tok(TK_ERROR, OP_NONE, pos, '0, line_nxt);
              mode_nxt = M_HALT;
            end
          endcase
          n_nxt = n_nxt + CNT_W'(1);
        end
      end

      bpos_nxt = bpos_r + OFF_W'(1);
    end

    // End of source: flush the pending lexeme, then eof unless halted
    if (last) begin
      unique case (mode_nxt)
        M_IDENT: begin
          tk_nxt[n_nxt] = make_tok(ident_kind(kwp_nxt, lcnt_nxt), OP_NONE, tstart_nxt,
                                   lcnt_nxt, line_nxt);
          n_nxt = n_nxt + CNT_W'(1);
        end
        M_INT, M_FRAC: begin
          tk_nxt[n_nxt] = make_tok(TK_NUMBER, OP_NONE, tstart_nxt, lcnt_nxt, line_nxt);
          n_nxt = n_nxt + CNT_W'(1);
        end
        M_DOT: begin
          tk_nxt[n_nxt] = make_tok(TK_NUMBER, OP_NONE, tstart_nxt, lcnt_nxt, line_nxt);
          n_nxt = n_nxt + CNT_W'(1);
          tk_nxt[n_nxt] = make_tok(TK_ERROR, OP_NONE, tstart_nxt + OFF_W'(lcnt_nxt),
                                   '0, line_nxt);
          n_nxt = n_nxt + CNT_W'(1);
          mode_nxt = M_HALT;
        end
        M_MINUS: begin
          tk_nxt[n_nxt] = make_tok(TK_OP, OP_SUB, tstart_nxt, LEN_W'(1), line_nxt);
          n_nxt = n_nxt + CNT_W'(1);
        end
        M_CMP: begin
          tk_nxt[n_nxt] = make_tok(TK_OP, cmp_op(pend_nxt, 1'b0), tstart_nxt, LEN_W'(1),
                                   line_nxt);
          n_nxt = n_nxt + CNT_W'(1);
        end
        M_IDLE, M_COMMENT, M_HALT: begin
        end
        default: begin
        end
      endcase
      if (mode_nxt != M_HALT) begin
        tk_nxt[n_nxt] = make_tok(TK_EOF, OP_NONE, bpos_nxt, '0, line_nxt);
        n_nxt = n_nxt + CNT_W'(1);
      end
    end

    // Number the tokens, saturating at the limit
    for (int i = 0; i < MAX_RES; i++) begin
      if (i < int'(n_nxt)) begin
        tk_nxt[i].index = temit_nxt;
        if (temit_nxt != IDX_MAX) temit_nxt = temit_nxt + IDX_W'(1);
      end
    end

    // Return to the reset state for the next source
    if (last) begin
      mode_nxt   = M_IDLE;
      pend_nxt   = '0;
      tstart_nxt = '0;
      lcnt_nxt   = '0;
      bpos_nxt   = '0;
      line_nxt   = LINE_ONE;
      kwp_nxt    = '0;
      temit_nxt  = '0;
    end
  end

  // Hand the bundle to the queue when the byte caused any token
  assign push_valid = in_acc & (n_nxt != '0);
  always_comb begin
    push_data.cnt = n_nxt;
    for (int i = 0; i < MAX_RES; i++) push_data.toks[i] = tk_nxt[i];
  end

  // Advance the scanner state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pend_r   <= '0;
      tstart_r <= '0;
      lcnt_r   <= '0;
      bpos_r   <= '0;
      line_r   <= LINE_ONE;
      kwp_r    <= '0;
      temit_r  <= '0;
    end else if (in_acc) begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      tstart_r <= tstart_nxt;
      lcnt_r   <= lcnt_nxt;
      bpos_r   <= bpos_nxt;
      line_r   <= line_nxt;
      kwp_r    <= kwp_nxt;
      temit_r  <= temit_nxt;
    end
  end

endmodule

@@ sv/stl_queue.sv @@
`timescale 1ns / 1ps
// Small FIFO of token bundles between the scanner and the serializer.
// Depends on stl_pkg.
module stl_queue import stl_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  bundle_t         push_data,
  output logic            push_ready,
  output logic            head_valid,
  output bundle_t         head_data,
  input  logic            pop,
  output logic [Q_CW-1:0] q_count
);

  bundle_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != Q_CW'(Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head_data  = mem_r[rd_ptr_r];
  assign q_count    = count_r;

  assign do_push = push_valid & push_ready;
  assign do_pop  = pop & head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push) count_nxt = count_nxt + Q_CW'(1);
    if (do_pop)  count_nxt = count_nxt - Q_CW'(1);
  end

  // Store the incoming bundle
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      count_r <= count_nxt;
    end
  end

endmodule

@@ sv/stl_back.sv @@
`timescale 1ns / 1ps
// Token serializer: walks the head bundle and sends one token per beat,
// marking the last token of each byte. Depends on stl_pkg and stl_out_if.
module stl_back import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  bundle_t   head_data,
  output logic      pop,
  stl_out_if.source out_ch
);

  logic [CNT_W-1:0] sub_r, sub_nxt;
  tok_t             cur;
  logic             is_last;
  logic             out_acc;

  assign cur     = head_data.toks[sub_r];
  assign is_last = sub_r == (head_data.cnt - CNT_W'(1));
  assign out_acc = out_ch.valid & out_ch.ready;
  assign pop     = out_acc & is_last;

  // Drive the token under the cursor
  assign out_ch.valid         = head_valid;
  assign out_ch.token_kind    = cur.kind;
  assign out_ch.op_code       = cur.op;
  assign out_ch.start_offset  = 16'(cur.start);
  assign out_ch.lexeme_length = cur.len;
  assign out_ch.line_number   = cur.line;
  assign out_ch.token_index   = cur.index;
  assign out_ch.last_of_run   = is_last;

  // Step through the bundle; rewind once it is popped
  always_comb begin
    sub_nxt = sub_r;
    if (pop)          sub_nxt = '0;
    else if (out_acc) sub_nxt = sub_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sub_r <= '0;
    else        sub_r <= sub_nxt;
  end

endmodule

@@ sv/script_token_lexer.sv @@
`timescale 1ns / 1ps
// Byte-serial lexer. One source byte is accepted per cycle whenever the token
// queue has room; the scanner classifies it in that cycle and pushes the bundle
// of up to three tokens it causes into a four-entry queue. The serializer sends
// one token per cycle while the output is ready; a byte's tokens are registered
// in the queue first. Sustained throughput is one byte per cycle while the text
// averages no more than one token per byte; the four-bundle queue absorbs bytes
// that yield two or three tokens, and input stalls only when it is full.
// Depends on stl_pkg, stl_if, stl_front, stl_queue and stl_back.
module script_token_lexer import stl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  stl_in_if.sink    in_chan,
  stl_out_if.source out_chan
);

  logic            q_push_valid;
  bundle_t         q_push_data;
  logic            q_push_ready;
  logic            q_head_valid;
  bundle_t         q_head_data;
  logic            q_pop;
  logic [Q_CW-1:0] q_count;

  stl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan),
    .push_valid (q_push_valid),
    .push_data  (q_push_data),
    .push_ready (q_push_ready)
  );

  stl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_data  (q_push_data),
    .push_ready (q_push_ready),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .q_count    (q_count)
  );

  stl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_ch     (out_chan)
  );

`ifndef SYNTHESIS
  // Occupancy never runs past the queue depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CW'(Q_DEPTH))
    else $error("token queue overflow");

  // Only non-empty bundles are queued
  a_q_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_head_valid |-> q_head_data.cnt != '0)
    else $error("empty bundle at queue head");

  // A byte's tokens go out without gaps
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && !out_chan.last_of_run |=> out_chan.valid)
    else $error("token run broken before its last beat");
`endif

endmodule
